/* hw/rtl/lcd_pkg.sv */
// Package for the line command decoder: field widths, character and code
// constants, and the keyword tables used while a line is checked.
// No dependencies.
`default_nettype none

package lcd_pkg;

  // Default sizes of the line memory and of the tool name store.
  localparam int LINE_DEPTH_DEF = 128;
  localparam int TOOL_DEPTH_DEF = 16;

  // Payload widths on the two channels.
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 136;

  // Widest tool name the result item can carry, in characters.
  localparam int TOOL_MAX = 15;

  // Number of leading line characters that decide the outcome of a line:
  // two of header, five of tool prefix and up to fifteen of tool name.
  localparam int SCAN_MAX = 22;
  localparam int SCAN_PW  = 5;

  // Button and byte codes carried in the input item.
  localparam logic [2:0] FN_BYTE   = 3'd0;
  localparam logic [2:0] FN_DENY   = 3'd1;
  localparam logic [2:0] FN_ALLOW  = 3'd2;
  localparam logic [2:0] FN_ALWAYS = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_BKSP   = 3'd5;
  localparam logic [2:0] FN_ENTER  = 3'd6;
  localparam logic [2:0] UL_NONE   = 3'd0;

  // Display state codes.
  localparam logic [2:0] DS_IDLE     = 3'd0;
  localparam logic [2:0] DS_THINKING = 3'd1;
  localparam logic [2:0] DS_WORKING  = 3'd2;
  localparam logic [2:0] DS_JUGGLING = 3'd3;
  localparam logic [2:0] DS_NOTIFY   = 3'd4;
  localparam logic [2:0] DS_ERROR    = 3'd5;
  localparam logic [2:0] DS_HAPPY    = 3'd6;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;

  localparam int KW_COUNT = 6;

  // Length of a display state name.
  function automatic logic [3:0] kw_len(input logic [2:0] idx);
    case (idx)
      3'd0:    kw_len = 4'd8;
      3'd1:    kw_len = 4'd7;
      3'd2:    kw_len = 4'd8;
      3'd3:    kw_len = 4'd6;
      3'd4:    kw_len = 4'd5;
      3'd5:    kw_len = 4'd5;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // Display code that a state name selects.
  function automatic logic [2:0] kw_code(input logic [2:0] idx);
    case (idx)
      3'd0:    kw_code = DS_THINKING;
      3'd1:    kw_code = DS_WORKING;
      3'd2:    kw_code = DS_JUGGLING;
      3'd3:    kw_code = DS_NOTIFY;
      3'd4:    kw_code = DS_ERROR;
      3'd5:    kw_code = DS_HAPPY;
      default: kw_code = DS_IDLE;
    endcase
  endfunction

  // Character at a position of a state name; zero past its end.
  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [63:0] txt;
    logic [3:0]  len;
    int          b;
    case (idx)
      3'd0:    txt = 64'("thinking");
      3'd1:    txt = 64'("working");
      3'd2:    txt = 64'("juggling");
      3'd3:    txt = 64'("notify");
      3'd4:    txt = 64'("error");
      3'd5:    txt = 64'("happy");
      default: txt = '0;
    endcase
    len = kw_len(idx);
    kw_char = CH_NUL;
    if (pos < len) begin
      b = 8 * (int'(len) - 1 - int'(pos));
      kw_char = txt[b +: 8];
    end
  endfunction

  // Character at a position of the tool prefix.
  function automatic logic [7:0] pfx_char(input logic [2:0] pos);
    logic [39:0] txt;
    int          b;
    txt = 40'("tool=");
    pfx_char = CH_NUL;
    if (pos < 3'd5) begin
      b = 8 * (4 - int'(pos));
      pfx_char = txt[b +: 8];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/line_command_decoder_unit.sv */
// Line command decoder: builds text lines from received bytes in a line
// memory, decodes them at each newline, and turns button events into codes.
// Depends on lcd_pkg.
//
// Every input item gives exactly one result item. A received byte other than
// a newline, a newline that ends an empty line, and every button event each
// load the output register directly. A newline that ends a non-empty line
// has the line read back and checked first, less of it if a zero byte cuts
// it short: the line memory has one read port with a registered read and is
// read one character a cycle, and only the first 22 characters can change
// the outcome. A new item is taken only while no line decode is running and
// the output register is empty or hands its item on in the same cycle.
`default_nettype none

module line_command_decoder_unit #(
  parameter int LINE_DEPTH = lcd_pkg::LINE_DEPTH_DEF,
  parameter int TOOL_DEPTH = lcd_pkg::TOOL_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input items.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [lcd_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  input  wire logic [lcd_pkg::IN_USER_W-1:0]   in_tuser,   // [2:0] func, [3] from_serial
  // Result items.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [2:0] display_state, [3] permission_pending, [7:4] tool_length,
  // [71:8] tool_chars_low, [127:72] tool_chars_high, [128] link_report_valid,
  // [129] link_up, [130] serial_activity, [131] monitor_request,
  // [134:132] uplink_code, [135] zero
  output logic [lcd_pkg::OUT_DATA_W-1:0]       out_tdata
);

  import lcd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int TL = TOOL_DEPTH - 1;
  localparam int PW = SCAN_PW;
  localparam int CW = (AW > PW) ? AW : PW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Control state.
  state_t               state_r, state_nxt;
  logic [AW-1:0]        line_len_r, line_len_nxt;
  logic [2:0]           shown_r, shown_nxt;
  logic                 pend_r, pend_nxt;
  logic [3:0]           tcnt_r, tcnt_nxt;
  logic [7:0]           tool_r [TL];
  logic [7:0]           tool_nxt [TL];
  logic [PW-1:0]        lim_r, lim_nxt;
  logic                 serial_r, serial_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Scan payload.
  logic [PW-1:0]        data_pos_r;
  logic [PW-1:0]        n_r;
  logic [7:0]           c0_r, c1_r, c2_r;
  logic [KW_COUNT-1:0]  name_ok_r;
  logic                 pfx_ok_r;
  logic [7:0]           stage_r [TL];

  // Line memory.
  logic [7:0]           line_mem [LINE_DEPTH];
  logic [7:0]           rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  // Handshake and input fields.
  logic                 in_acc;
  logic                 out_free;
  logic [2:0]           in_func;
  logic                 in_serial;
  logic [7:0]           in_byte;
  logic                 scan_start;
  logic                 scan_issue;

  // Result fields.
  logic                 out_load;
  logic                 link_v, link_up, act, mon;
  logic [2:0]           code;
  logic [PW-1:0]        k_len;
  logic [TOOL_MAX-1:0][7:0] tool_bytes;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign in_func   = in_tuser[2:0];
  assign in_serial = in_tuser[3];
  assign in_byte   = in_tdata;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = rst_n && (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign scan_start = in_acc && (in_func == FN_BYTE) && (in_byte == CH_LF) &&
                      (line_len_r != '0);
  assign scan_issue = (state_r == S_SCAN) && (rd_ptr_r < lim_r);
  assign rd_addr    = AW'(rd_ptr_r);
  assign k_len      = ((n_r - PW'(7)) > PW'(TL)) ? PW'(TL) : (n_r - PW'(7));

  // Next state of the decoder and the content of the next result item.
  always_comb begin
    state_nxt    = state_r;
    line_len_nxt = line_len_r;
    shown_nxt    = shown_r;
    pend_nxt     = pend_r;
    tcnt_nxt     = tcnt_r;
    tool_nxt     = tool_r;
    lim_nxt      = lim_r;
    serial_nxt   = serial_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_vld_nxt   = 1'b0;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    link_v       = 1'b0;
    link_up      = 1'b0;
    act          = 1'b0;
    mon          = 1'b0;
    code         = UL_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (in_func)
            FN_BYTE: begin
              if (in_byte == CH_CR) begin
                // Carriage returns are dropped.
              end else if (in_byte == CH_LF) begin
                if (line_len_r != '0) begin
                  // A non-empty line is decoded before the result goes out.
                  out_load     = 1'b0;
                  state_nxt    = S_SCAN;
                  serial_nxt   = in_serial;
                  rd_ptr_nxt   = '0;
                  line_len_nxt = '0;
                  if (CW'(line_len_r) > CW'(SCAN_MAX)) begin
                    lim_nxt = PW'(SCAN_MAX);
                  end else begin
                    lim_nxt = PW'(line_len_r);
                  end
                end
              end else if (line_len_r < AW'(LINE_DEPTH - 1)) begin
                wr_en        = 1'b1;
                line_len_nxt = line_len_r + 1'b1;
              end else begin
                // Overflow drops the byte and restarts the line.
                line_len_nxt = '0;
              end
            end
            FN_DENY, FN_ALLOW, FN_ALWAYS: begin
              if (pend_r) begin
                code     = in_func;
                pend_nxt = 1'b0;
                tcnt_nxt = '0;
                for (int t = 0; t < TL; t++) begin
                  tool_nxt[t] = '0;
                end
              end
            end
            FN_CLEAR, FN_BKSP, FN_ENTER: begin
              if (!pend_r) begin
                code = in_func;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // One read issued and one character checked each cycle.
        if (scan_issue) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        rd_vld_nxt = scan_issue;
        if (rd_vld_r && ((rd_data_r == CH_NUL) || (data_pos_r == lim_r - 1'b1))) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (n_r != '0) begin
            act = serial_r && ((c0_r == CH_S) || (c0_r == CH_P));
            if ((c0_r == CH_L) && (c1_r == CH_COLON)) begin
              link_v  = 1'b1;
              link_up = (c2_r == CH_ONE);
            end else if ((c0_r == CH_S) && (c1_r == CH_COLON)) begin
              if (n_r != PW'(2)) begin
                // First matching name wins; anything else is idle.
                shown_nxt = DS_IDLE;
                for (int i = KW_COUNT - 1; i >= 0; i--) begin
                  if (name_ok_r[i] && (n_r == PW'(2) + PW'(kw_len(3'(i))))) begin
                    shown_nxt = kw_code(3'(i));
                  end
                end
              end
            end else if ((c0_r == CH_P) && (c1_r == CH_COLON)) begin
              if (n_r == PW'(2)) begin
                pend_nxt = 1'b0;
                tcnt_nxt = '0;
                for (int t = 0; t < TL; t++) begin
                  tool_nxt[t] = '0;
                end
              end else if ((n_r >= PW'(7)) && pfx_ok_r) begin
                // Permission request: take the tool name and ask for notice.
                for (int t = 0; t < TL; t++) begin
                  tool_nxt[t] = (PW'(t) < k_len) ? stage_r[t] : 8'h00;
                end
                tcnt_nxt  = 4'(k_len);
                pend_nxt  = 1'b1;
                shown_nxt = DS_NOTIFY;
                mon       = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Tool name bytes as the result item shows them.
  always_comb begin
    tool_bytes = '0;
    for (int t = 0; t < TL; t++) begin
      tool_bytes[t] = tool_nxt[t];
    end
  end

  assign out_data_nxt = {1'b0, code, mon, act, link_up, link_v,
                         tool_bytes[TOOL_MAX-1:8], tool_bytes[7:0],
                         tcnt_nxt, pend_nxt, shown_nxt};

  // State machine, decoder state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      line_len_r  <= '0;
      shown_r     <= DS_IDLE;
      pend_r      <= 1'b0;
      tcnt_r      <= '0;
      for (int t = 0; t < TL; t++) begin
        tool_r[t] <= '0;
      end
      lim_r       <= '0;
      serial_r    <= 1'b0;
      rd_ptr_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      line_len_r <= line_len_nxt;
      shown_r    <= shown_nxt;
      pend_r     <= pend_nxt;
      tcnt_r     <= tcnt_nxt;
      tool_r     <= tool_nxt;
      lim_r      <= lim_nxt;
      serial_r   <= serial_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      rd_vld_r   <= rd_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-character checks while the line is read back.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      n_r       <= '0;
      c0_r      <= CH_NUL;
      c1_r      <= CH_NUL;
      c2_r      <= CH_NUL;
      name_ok_r <= '1;
      pfx_ok_r  <= 1'b1;
    end else if (state_r == S_SCAN) begin
      data_pos_r <= rd_ptr_r;
      if (rd_vld_r && (rd_data_r != CH_NUL)) begin
        n_r <= data_pos_r + 1'b1;
        if (data_pos_r == PW'(0)) c0_r <= rd_data_r;
        if (data_pos_r == PW'(1)) c1_r <= rd_data_r;
        if (data_pos_r == PW'(2)) c2_r <= rd_data_r;
        if (data_pos_r >= PW'(2)) begin
          for (int i = 0; i < KW_COUNT; i++) begin
            if (!(((data_pos_r - PW'(2)) < PW'(kw_len(3'(i)))) &&
                  (rd_data_r == kw_char(3'(i), 4'(data_pos_r - PW'(2)))))) begin
              name_ok_r[i] <= 1'b0;
            end
          end
          if ((data_pos_r <= PW'(6)) &&
              (rd_data_r != pfx_char(3'(data_pos_r - PW'(2))))) begin
            pfx_ok_r <= 1'b0;
          end
        end
        for (int t = 0; t < TL; t++) begin
          if (data_pos_r == PW'(7 + t)) begin
            stage_r[t] <= rd_data_r;
          end
        end
      end
    end
  end

  // Line memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[line_len_r] <= in_byte;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  // Checks on the decoder's own bookkeeping.
  a_tool_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= 4'(TL))
    else $error("tool count beyond store size");

  a_monitor_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[131]) |->
      (out_data_r[3] && (out_data_r[2:0] == DS_NOTIFY)))
    else $error("monitor request without pending permission");

  a_answer_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_data_r[134:132] == FN_DENY) ||
                     (out_data_r[134:132] == FN_ALLOW) ||
                     (out_data_r[134:132] == FN_ALWAYS))) |->
      (!out_data_r[3] && (out_data_r[7:4] == 4'd0)))
    else $error("permission answer left a request pending");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("item taken during line decode");

  a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("decoded line gave no result item");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for line_command_decoder_unit: a short table of
// directed items, then random command lines, buttons and noise.
// Depends on lcd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module testbench;
  import lcd_pkg::*;

  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int LINE_CAP   = LINE_DEPTH_DEF;
  localparam int TOOL_KEEP  = (TOOL_DEPTH_DEF - 1 < TOOL_MAX) ? TOOL_DEPTH_DEF - 1 : TOOL_MAX;
  localparam int RAND_ITEMS = 1200;
  localparam int CALM_LO    = 2000;
  localparam int CALM_HI    = 5000;
  localparam int CYCLE_CAP  = 400000;
  localparam int TAIL       = 40;

  // One result item, laid out as on out_tdata (lowest field last).
  typedef struct packed {
    logic        pad;
    logic [2:0]  uplink;
    logic        monitor;
    logic        activity;
    logic        link_up;
    logic        link_valid;
    logic [55:0] chars_hi;
    logic [63:0] chars_lo;
    logic [3:0]  tool_len;
    logic        pending;
    logic [2:0]  disp;
  } status_t;

  // One input item, with an optional typed-in expected status.
  typedef struct {
    logic [2:0] func;
    logic [7:0] ch;
    logic       serial;
    logic       typed;
    status_t    want;
  } event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  line_command_decoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder state as the block should hold it.
  logic [7:0] line_mem [LINE_CAP];
  int         line_len;
  logic [2:0] shown;
  logic       perm_pending;
  logic [7:0] tool_mem [16];
  int         tool_cnt;

  string      state_word [6] = '{"thinking", "working", "juggling", "notify", "error", "happy"};
  logic [2:0] state_code [6] = '{DS_THINKING, DS_WORKING, DS_JUGGLING, DS_NOTIFY, DS_ERROR,
                                 DS_HAPPY};

  event_t  event_q [$];
  event_t  dir_tab [23];
  status_t status_q [$];
  event_t  on_bus;
  status_t predicted;
  status_t seen;
  status_t want;
  int      send_idx = 0;
  int      accepted = 0;
  int      results = 0;
  int      errors = 0;
  int      cyc = 0;
  logic    go = 1'b0;

  function automatic status_t plain(logic [2:0] d, logic p, logic [2:0] code, logic lv,
                                    logic lu, logic act, logic mon);
    status_t s;
    s = '0;
    s.disp = d;
    s.pending = p;
    s.uplink = code;
    s.link_valid = lv;
    s.link_up = lu;
    s.activity = act;
    s.monitor = mon;
    return s;
  endfunction

  // True when the held line has exactly the word w at position start.
  function automatic logic word_at(int start, int len, string w);
    if (len != w.len()) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (start + i >= LINE_CAP || line_mem[start + i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Work out the status that an accepted item leads to, and update the state.
  task automatic decode_item(input event_t e, output status_t r);
    int n;
    int k;
    logic [7:0] c0, c1, c2;
    logic [2:0] code;
    r = '0;
    if (e.func == FN_BYTE) begin
      if (e.ch == CH_CR) begin
        // Carriage returns are dropped.
      end else if (e.ch == CH_LF) begin
        if (line_len > 0) begin
          // The line ends at its first zero byte.
          n = 0;
          while (n < line_len && line_mem[n] != CH_NUL) n++;
          if (n > 0) begin
            c0 = line_mem[0];
            c1 = (n > 1) ? line_mem[1] : CH_NUL;
            c2 = (n > 2) ? line_mem[2] : CH_NUL;
            if (e.serial && (c0 == CH_S || c0 == CH_P)) r.activity = 1'b1;
            if (c0 == CH_L && c1 == CH_COLON) begin
              r.link_valid = 1'b1;
              r.link_up = (c2 == CH_ONE);
            end else if (c0 == CH_S && c1 == CH_COLON && n > 2) begin
              code = DS_IDLE;
              for (int i = 0; i < 6; i++) begin
                if (word_at(2, n - 2, state_word[i])) code = state_code[i];
              end
              shown = code;
            end else if (c0 == CH_P && c1 == CH_COLON) begin
              if (n == 2) begin
                perm_pending = 1'b0;
                tool_mem = '{default: 8'h00};
                tool_cnt = 0;
              end else if (n >= 7 && word_at(2, 5, "tool=")) begin
                k = (n - 7 > TOOL_KEEP) ? TOOL_KEEP : n - 7;
                tool_mem = '{default: 8'h00};
                for (int i = 0; i < k; i++) tool_mem[i] = line_mem[7 + i];
                tool_cnt = k;
                perm_pending = 1'b1;
                shown = DS_NOTIFY;
                r.monitor = 1'b1;
              end
            end
          end
          line_len = 0;
        end
      end else if (line_len < LINE_CAP - 1) begin
        line_mem[line_len] = e.ch;
        line_len++;
      end else begin
        // Overflow: the byte is lost and the line starts again.
        line_len = 0;
      end
    end else if (e.func <= FN_ALWAYS) begin
      if (perm_pending) begin
        r.uplink = e.func;
        perm_pending = 1'b0;
        tool_mem = '{default: 8'h00};
        tool_cnt = 0;
      end
    end else if (e.func <= FN_ENTER) begin
      if (!perm_pending) r.uplink = e.func;
    end
    r.disp = shown;
    r.pending = perm_pending;
    r.tool_len = tool_cnt[3:0];
    for (int i = 0; i < tool_cnt; i++) begin
      if (i < 8) r.chars_lo[8*i +: 8] = tool_mem[i];
      else r.chars_hi[8*(i-8) +: 8] = tool_mem[i];
    end
  endtask

  task automatic add_byte(logic [7:0] c);
    event_t e;
    e = '{FN_BYTE, c, 1'($urandom_range(0, 1)), 1'b0, '0};
    event_q.push_back(e);
  endtask

  task automatic add_btn(logic [2:0] f);
    event_t e;
    e = '{f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0};
    event_q.push_back(e);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Random line characters: mostly printable, sometimes any byte but newline and zero.
  task automatic add_chars(int lo, int hi);
    int n;
    logic [7:0] c;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      if ($urandom_range(0, 9) != 0) c = 8'($urandom_range(8'h21, 8'h7E));
      else begin
        c = 8'($urandom_range(1, 255));
        while (c == CH_LF) c = 8'($urandom_range(1, 255));
      end
      add_byte(c);
    end
  endtask

  task automatic end_line();
    if ($urandom_range(0, 4) == 0) add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  // Random command lines, mostly well formed, with buttons and noise between.
  task automatic fill_random();
    int pick;
    int sel;
    int goal;
    goal = event_q.size() + RAND_ITEMS;
    while (event_q.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        add_text("L:");
        if ($urandom_range(0, 1) != 0) add_byte(CH_ONE);
        else if ($urandom_range(0, 3) != 0) add_chars(1, 1);
        if ($urandom_range(0, 4) == 0) add_chars(1, 4);
        end_line();
      end else if (pick < 34) begin
        add_text("S:");
        sel = $urandom_range(0, 7);
        if (sel < 6) add_text(state_word[sel]);
        else if (sel == 6) add_chars(1, 9);
        else begin
          sel = $urandom_range(0, 5);
          add_text(state_word[sel].substr(0, state_word[sel].len() - 2));
        end
        if ($urandom_range(0, 9) == 0) add_chars(1, 2);
        end_line();
      end else if (pick < 59) begin
        add_text("P:tool=");
        if ($urandom_range(0, 3) == 0) add_chars(14, 22);
        else add_chars(0, 13);
        end_line();
        if ($urandom_range(0, 1) != 0)
          repeat ($urandom_range(1, 2)) add_btn(3'($urandom_range(1, 6)));
      end else if (pick < 64) begin
        add_text("P:");
        sel = $urandom_range(0, 2);
        if (sel == 1) add_chars(1, 6);
        else if (sel == 2) add_text("too");
        end_line();
      end else if (pick < 76) begin
        repeat ($urandom_range(1, 3)) add_btn(3'($urandom_range(1, 7)));
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) add_btn(3'($urandom_range(0, 7)));
          else add_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 91) begin
        // Lines cut short by a zero byte, or led by one.
        if ($urandom_range(0, 1) != 0) begin
          add_byte(CH_NUL);
          add_text("L:1");
        end else begin
          if ($urandom_range(0, 1) != 0) add_text("S:happy");
          else add_text("P:tool=x");
          add_byte(CH_NUL);
          add_chars(0, 4);
        end
        end_line();
      end else if (pick < 99) begin
        sel = $urandom_range(0, 4);
        case (sel)
          0: add_text("L");
          1: add_text("S");
          2: add_text("P");
          3: add_text("L:");
          default: add_text("S:");
        endcase
        end_line();
      end else begin
        // Lines around the overflow point.
        add_chars(LINE_CAP - 2, LINE_CAP + 1);
        if ($urandom_range(0, 1) != 0) add_text("S:error");
        end_line();
      end
    end
  endtask

  // Gaps at random, except in one calm stretch of the run.
  function automatic logic take_break();
    if (cyc >= CALM_LO && cyc < CALM_HI) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch on result %0d, %s: expected %h, got %h", results, name, exp_v,
                 got_v);
    end
  endtask

  // Drive input items and predict each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_item(on_bus, predicted);
        status_q.push_back(on_bus.typed ? on_bus.want : predicted);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (go && send_idx < event_q.size() && !take_break()) begin
          on_bus = event_q[send_idx];
          send_idx++;
          in_tvalid <= 1'b1;
          in_tdata <= on_bus.ch;
          in_tuser <= {on_bus.serial, on_bus.func};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take result items and compare them with the oldest predicted status.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result item %h", out_tdata);
        end else begin
          want = status_q.pop_front();
          check_field("display_state", 64'(want.disp), 64'(seen.disp));
          check_field("permission_pending", 64'(want.pending), 64'(seen.pending));
          check_field("tool_length", 64'(want.tool_len), 64'(seen.tool_len));
          check_field("tool_chars_low", want.chars_lo, seen.chars_lo);
          check_field("tool_chars_high", 64'(want.chars_hi), 64'(seen.chars_hi));
          check_field("link_report_valid", 64'(want.link_valid), 64'(seen.link_valid));
          check_field("link_up", 64'(want.link_up), 64'(seen.link_up));
          check_field("serial_activity", 64'(want.activity), 64'(seen.activity));
          check_field("monitor_request", 64'(want.monitor), 64'(seen.monitor));
          check_field("uplink_code", 64'(want.uplink), 64'(seen.uplink));
          check_field("spare bit", 64'(want.pad), 64'(seen.pad));
        end
        results++;
      end
      out_tready <= !take_break();
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    line_mem = '{default: 8'h00};
    line_len = 0;
    shown = DS_IDLE;
    perm_pending = 1'b0;
    tool_mem = '{default: 8'h00};
    tool_cnt = 0;

    // Directed items: buttons and lines straight after reset, a link report,
    // an empty tool name, an allow that answers it, then buttons with none pending.
    dir_tab = '{
      '{FN_DENY,   CH_NUL,   1'b0, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_UNUSED, 8'hFF,    1'b1, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_CLEAR,  CH_NUL,   1'b0, 1'b1,
        plain(DS_IDLE, 1'b0, FN_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BYTE,   8'hFF,    1'b1, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BYTE,   CH_LF,    1'b1, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BYTE,   CH_LF,    1'b0, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BYTE,   CH_L,     1'b0, 1'b0, '0},
      '{FN_BYTE,   CH_COLON, 1'b1, 1'b0, '0},
      '{FN_BYTE,   CH_ONE,   1'b0, 1'b0, '0},
      '{FN_BYTE,   CH_LF,    1'b1, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b1, 1'b1, 1'b0, 1'b0)},
      '{FN_BYTE,   CH_CR,    1'b0, 1'b1,
        plain(DS_IDLE, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BYTE,   CH_P,     1'b1, 1'b0, '0},
      '{FN_BYTE,   CH_COLON, 1'b0, 1'b0, '0},
      '{FN_BYTE,   "t",      1'b1, 1'b0, '0},
      '{FN_BYTE,   "o",      1'b0, 1'b0, '0},
      '{FN_BYTE,   "o",      1'b1, 1'b0, '0},
      '{FN_BYTE,   "l",      1'b0, 1'b0, '0},
      '{FN_BYTE,   "=",      1'b1, 1'b0, '0},
      '{FN_BYTE,   CH_LF,    1'b1, 1'b1,
        plain(DS_NOTIFY, 1'b1, UL_NONE, 1'b0, 1'b0, 1'b1, 1'b1)},
      '{FN_ALLOW,  CH_NUL,   1'b0, 1'b1,
        plain(DS_NOTIFY, 1'b0, FN_ALLOW, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_ALWAYS, 8'hFF,    1'b1, 1'b1,
        plain(DS_NOTIFY, 1'b0, UL_NONE, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_ENTER,  CH_NUL,   1'b0, 1'b1,
        plain(DS_NOTIFY, 1'b0, FN_ENTER, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{FN_BKSP,   8'hFF,    1'b1, 1'b1,
        plain(DS_NOTIFY, 1'b0, FN_BKSP, 1'b0, 1'b0, 1'b0, 1'b0)}
    };
    foreach (dir_tab[i]) event_q.push_back(dir_tab[i]);
    fill_random();

    // Hold reset, then release it and start sending.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    go <= 1'b1;

    while (accepted < event_q.size()) @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (errors == 0 && status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lcd_pkg.sv
hw/rtl/line_command_decoder_unit.sv
test/testbench.sv
